[hw/rtl/priority_task_table_macros.svh]
// ----------------------------------------------------------------------------
// priority_task_table_macros
// Assertion macros for the priority task table. They expand to nothing in
// synthesis builds.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_TASK_TABLE_MACROS_SVH
`define PRIORITY_TASK_TABLE_MACROS_SVH

`ifndef SYNTHESIS

// Check a condition at every clock edge outside reset.
`define PTT_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check that a consequence holds in the cycle after its trigger.
`define PTT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define PTT_ASSERT(lbl, cond, msg)
`define PTT_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[hw/rtl/ptt_pkg.sv]
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared sizes, codes and types of the priority task table.
// ----------------------------------------------------------------------------
`default_nettype none

package ptt_pkg;

	// Table size and derived widths
	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int POS_CMP_W = (CNT_W > 4) ? CNT_W : 4;

	// Action codes
	localparam logic [2:0] ACT_ADD    = 3'd0;
	localparam logic [2:0] ACT_DELETE = 3'd1;
	localparam logic [2:0] ACT_SORT   = 3'd2;
	localparam logic [2:0] ACT_SEARCH = 3'd3;
	localparam logic [2:0] ACT_READ   = 3'd4;

	// Status codes
	localparam logic [2:0] STAT_OK        = 3'd0;
	localparam logic [2:0] STAT_NOT_FOUND = 3'd1;
	localparam logic [2:0] STAT_FULL      = 3'd2;
	localparam logic [2:0] STAT_EMPTY     = 3'd3;
	localparam logic [2:0] STAT_TOO_FEW   = 3'd4;
	localparam logic [2:0] STAT_RANGE     = 3'd5;

	// One stored task
	typedef struct packed {
		logic [15:0] id;
		logic [7:0]  prio;
		logic [31:0] payload;
	} ptt_entry_t;

	localparam int ENTRY_W = $bits(ptt_entry_t);

	// One request word
	typedef struct packed {
		logic [2:0]  action;
		logic [15:0] task_id;
		logic [7:0]  priority_req;
		logic [31:0] payload;
		logic [3:0]  position;
	} ptt_req_t;

	// One result word
	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  found_index;
		logic [15:0] out_id;
		logic [7:0]  out_priority;
		logic [31:0] out_payload;
		logic [4:0]  entry_count;
	} ptt_res_t;

endpackage

`default_nettype wire

[hw/rtl/ptt_ram.sv]
// ----------------------------------------------------------------------------
// ptt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ptt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[hw/rtl/ptt_engine.sv]
// ----------------------------------------------------------------------------
// ptt_engine
// Sequencer around the task memory: append, read, walk for search and delete,
// and the exchange sort as row walks with the row entry held in a register.
// ----------------------------------------------------------------------------
`default_nettype none

module ptt_engine (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire ptt_pkg::ptt_req_t req,
	output logic                   idle,
	output logic                   res_valid,
	input  wire logic              res_ready,
	output ptt_pkg::ptt_res_t      res
);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_WALK    = 3'd1;
	localparam logic [2:0] S_ROW_END = 3'd2;
	localparam logic [2:0] S_RD_WAIT = 3'd3;
	localparam logic [2:0] S_RESP    = 3'd4;

	logic [2:0]                    state_q;
	logic [2:0]                    op_q;
	logic [15:0]                   key_q;
	logic [ptt_pkg::CNT_W-1:0]     count_q;
	logic [ptt_pkg::CNT_W-1:0]     rd_idx_q;
	logic                          vld_s1;
	logic [ptt_pkg::IDX_W-1:0]     idx_s1;
	logic [ptt_pkg::IDX_W-1:0]     row_q;
	ptt_pkg::ptt_entry_t           cur_q;
	logic                          found_q;
	logic [3:0]                    fidx_q;
	logic [2:0]                    status_q;
	ptt_pkg::ptt_entry_t           rdat_q;

	logic                          we;
	logic [ptt_pkg::IDX_W-1:0]     waddr;
	logic [ptt_pkg::IDX_W-1:0]     raddr;
	ptt_pkg::ptt_entry_t           wr_ent;
	ptt_pkg::ptt_entry_t           rd_ent;
	logic                          walk_issue;
	logic                          id_hit;
	logic                          prio_gt;
	logic                          row_head;
	logic                          pos_ok;

	ptt_ram #(
		.WIDTH(ptt_pkg::ENTRY_W),
		.DEPTH(ptt_pkg::DEPTH)
	) u_mem (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wr_ent),
		.raddr(raddr),
		.rdata(rd_ent)
	);

	// Walk decode
	assign walk_issue = (state_q == S_WALK) && (rd_idx_q < count_q);
	assign id_hit     = (rd_ent.id == key_q);
	assign prio_gt    = (rd_ent.prio > cur_q.prio);
	assign row_head   = (idx_s1 == row_q);
	assign pos_ok     = ptt_pkg::POS_CMP_W'(req.position) < ptt_pkg::POS_CMP_W'(count_q);

	// Read address: requested position on a read, walk pointer otherwise
	always_comb begin
		if (state_q == S_IDLE) begin
			raddr = ptt_pkg::IDX_W'(req.position);
		end else begin
			raddr = rd_idx_q[ptt_pkg::IDX_W-1:0];
		end
	end

	// Write port: append, close the gap, swap out, row write-back
	always_comb begin
		we     = 1'b0;
		waddr  = '0;
		wr_ent = '0;
		case (state_q)
			S_IDLE: begin
				if (start && (req.action == ptt_pkg::ACT_ADD) &&
				    (count_q < ptt_pkg::CNT_W'(ptt_pkg::DEPTH))) begin
					we             = 1'b1;
					waddr          = count_q[ptt_pkg::IDX_W-1:0];
					wr_ent.id      = req.task_id;
					wr_ent.prio    = req.priority_req;
					wr_ent.payload = req.payload;
				end
			end
			S_WALK: begin
				if (vld_s1 && (op_q == ptt_pkg::ACT_DELETE) && found_q) begin
					we     = 1'b1;
					waddr  = idx_s1 - ptt_pkg::IDX_W'(1);
					wr_ent = rd_ent;
				end else if (vld_s1 && (op_q == ptt_pkg::ACT_SORT) && !row_head && prio_gt) begin
					we     = 1'b1;
					waddr  = idx_s1;
					wr_ent = cur_q;
				end
			end
			S_ROW_END: begin
				we     = 1'b1;
				waddr  = row_q;
				wr_ent = cur_q;
			end
			default: begin
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			vld_s1   <= 1'b0;
			found_q  <= 1'b0;
			rd_idx_q <= '0;
			row_q    <= '0;
		end else begin
			vld_s1 <= walk_issue;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						found_q  <= 1'b0;
						rd_idx_q <= '0;
						row_q    <= '0;
						case (req.action)
							ptt_pkg::ACT_ADD: begin
								if (count_q < ptt_pkg::CNT_W'(ptt_pkg::DEPTH)) begin
									count_q <= count_q + ptt_pkg::CNT_W'(1);
								end
								state_q <= S_RESP;
							end
							ptt_pkg::ACT_DELETE,
							ptt_pkg::ACT_SEARCH: begin
								state_q <= (count_q == '0) ? S_RESP : S_WALK;
							end
							ptt_pkg::ACT_SORT: begin
								state_q <= (count_q < ptt_pkg::CNT_W'(2)) ? S_RESP : S_WALK;
							end
							ptt_pkg::ACT_READ: begin
								state_q <= pos_ok ? S_RD_WAIT : S_RESP;
							end
							default: begin
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_WALK: begin
					if (walk_issue) begin
						rd_idx_q <= rd_idx_q + ptt_pkg::CNT_W'(1);
					end
					if (vld_s1 && !found_q && id_hit) begin
						found_q <= 1'b1;
					end
					// Walk drained: finish the action or close the sort row
					if (!walk_issue && !vld_s1) begin
						if (op_q == ptt_pkg::ACT_SORT) begin
							state_q <= S_ROW_END;
						end else begin
							if ((op_q == ptt_pkg::ACT_DELETE) && found_q) begin
								count_q <= count_q - ptt_pkg::CNT_W'(1);
							end
							state_q <= S_RESP;
						end
					end
				end
				S_ROW_END: begin
					// Advance to the next row while it has a later entry
					if ((ptt_pkg::CNT_W'(row_q) + ptt_pkg::CNT_W'(2)) < count_q) begin
						row_q    <= row_q + ptt_pkg::IDX_W'(1);
						rd_idx_q <= ptt_pkg::CNT_W'(row_q) + ptt_pkg::CNT_W'(1);
						state_q  <= S_WALK;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_RD_WAIT: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q[ptt_pkg::IDX_W-1:0];
		case (state_q)
			S_IDLE: begin
				if (start) begin
					op_q     <= req.action;
					key_q    <= req.task_id;
					fidx_q   <= '0;
					rdat_q   <= '0;
					status_q <= ptt_pkg::STAT_OK;
					case (req.action)
						ptt_pkg::ACT_ADD: begin
							if (count_q >= ptt_pkg::CNT_W'(ptt_pkg::DEPTH)) begin
								status_q <= ptt_pkg::STAT_FULL;
							end
						end
						ptt_pkg::ACT_DELETE: begin
							if (count_q == '0) begin
								status_q <= ptt_pkg::STAT_EMPTY;
							end
						end
						ptt_pkg::ACT_SEARCH: begin
							if (count_q == '0) begin
								status_q <= ptt_pkg::STAT_NOT_FOUND;
							end
						end
						ptt_pkg::ACT_SORT: begin
							if (count_q < ptt_pkg::CNT_W'(2)) begin
								status_q <= ptt_pkg::STAT_TOO_FEW;
							end
						end
						ptt_pkg::ACT_READ: begin
							if (!pos_ok) begin
								status_q <= ptt_pkg::STAT_RANGE;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_WALK: begin
				// Record the first match of a search
				if (vld_s1 && !found_q && id_hit && (op_q == ptt_pkg::ACT_SEARCH)) begin
					fidx_q <= 4'(idx_s1);
				end
				// Hold the row entry; take the larger one on a swap
				if (vld_s1 && (op_q == ptt_pkg::ACT_SORT) && (row_head || prio_gt)) begin
					cur_q <= rd_ent;
				end
				if (!walk_issue && !vld_s1 && (op_q != ptt_pkg::ACT_SORT) && !found_q) begin
					status_q <= ptt_pkg::STAT_NOT_FOUND;
				end
			end
			S_RD_WAIT: begin
				rdat_q <= rd_ent;
			end
			default: begin
			end
		endcase
	end

	// Result
	assign idle              = (state_q == S_IDLE);
	assign res_valid         = (state_q == S_RESP);
	assign res.status        = status_q;
	assign res.found_index   = fidx_q;
	assign res.out_id        = rdat_q.id;
	assign res.out_priority  = rdat_q.prio;
	assign res.out_payload   = rdat_q.payload;
	assign res.entry_count   = 5'(count_q);

endmodule

`default_nettype wire

[hw/rtl/priority_task_table.sv]
// ----------------------------------------------------------------------------
// priority_task_table
// Ordered table of tasks (id, priority, payload) with add, delete, sort,
// search and read actions over a streaming request and result channel.
// ----------------------------------------------------------------------------
// Usage:
//   Each request word on the s_ channel carries one action and yields exactly
//   one result word on the m_ channel, in order.
//   One request is worked on at a time; s_tready is high while the sequencer
//   is idle, also while the previous result still waits in the output
//   register.
//   Work per action, with N tasks held:
//     add, read, unused codes and early errors: no walk over the entries
//     search and delete: a walk with one memory read per entry
//     sort: each row of the exchange sort walks its own and the later
//     entries through the single read port of the task memory and ends
//     with a write-back of the row entry.
//   Reset clears the task count; the task memory is not cleared and entries
//   beyond the count are never used.
//   When m_tready is low the result holds in the output register; a further
//   finished result waits in the sequencer, which then takes no new request.
// ----------------------------------------------------------------------------
`default_nettype none

`include "priority_task_table_macros.svh"

module priority_task_table (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// action[2:0], task_id[18:3], priority_req[26:19], payload[58:27],
	// position[62:59], zero[63]
	input  wire logic [63:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// status[2:0], found_index[6:3], out_id[22:7], out_priority[30:23],
	// out_payload[62:31], entry_count[67:63], zero[71:68]
	output logic      [71:0] m_tdata
);

	ptt_pkg::ptt_req_t req;
	ptt_pkg::ptt_res_t res;
	ptt_pkg::ptt_res_t out_q;
	logic              m_tvalid_q;
	logic              start;
	logic              eng_idle;
	logic              res_valid;
	logic              res_ready;

	// Unpack the request word
	assign req.action       = s_tdata[2:0];
	assign req.task_id      = s_tdata[18:3];
	assign req.priority_req = s_tdata[26:19];
	assign req.payload      = s_tdata[58:27];
	assign req.position     = s_tdata[62:59];

	assign s_tready  = eng_idle;
	assign start     = s_tvalid && eng_idle;
	assign res_ready = !m_tvalid_q || m_tready;

	ptt_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req      (req),
		.idle     (eng_idle),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	// Output register: load a finished result, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'b0, out_q.entry_count, out_q.out_payload, out_q.out_priority,
	                   out_q.out_id, out_q.found_index, out_q.status};

	// Checks
	`PTT_ASSERT_NEXT(a_accept_busy, start, !eng_idle, "sequencer idle after accepting a word")
	`PTT_ASSERT(a_idle_no_res, !(eng_idle && res_valid), "result offered while idle")
	`PTT_ASSERT_NEXT(a_res_held, res_valid && !res_ready, res_valid, "stalled result dropped")
	`PTT_ASSERT(a_status_code, !m_tvalid_q || (out_q.status <= ptt_pkg::STAT_RANGE),
		"status code out of range")

endmodule

`default_nettype wire
